/* design/fuzzy_substring_matcher_defines.svh */
// Assertion macros for the fuzzy substring matcher.
// Included by the files that carry concurrent assertions; needs a clock and reset in scope.
`ifndef FUZZY_SUBSTRING_MATCHER_DEFINES_SVH
`define FUZZY_SUBSTRING_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define FZM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define FZM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FZM_ASSERT_IMPLY(label, ante, cons, msg)
`define FZM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/fzm_pkg.sv */
// Shared types, constants and helper functions of the fuzzy substring matcher.
// Used by the register block, the controller, the datapath and the top level.
package fzm_pkg;

   localparam int MaxQuery   = 16;
   localparam int RowWidth   = $clog2(MaxQuery + 1);
   localparam int ColDepth   = MaxQuery + 1;
   localparam int QueryBits  = 128;
   localparam int CharIdxW   = 4;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 64;
   localparam int LenWidth   = 5;

   typedef logic [RowWidth-1:0] dist_type;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_QUERY_LOW  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_QUERY_HIGH = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_QUERY_LEN  = 2'd2;

   // Input kind codes.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic     load_char;
      logic     step;
      logic     last_step;
      dist_type row;
      logic     close_name;
      logic     restart;
   } dp_cmd_type;

   typedef struct packed {
      logic out_full;
   } dp_status_type;

   // Only A-Z are folded to lower case.
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic [7:0] query_char(input logic [QueryBits-1:0] q,
                                             input logic [CharIdxW-1:0] idx);
      return fold(q[idx*8 +: 8]);
   endfunction

   function automatic dist_type allowance(input dist_type n);
      dist_type a;
      if (n < dist_type'(3)) begin
         a = '0;
      end else if (n <= dist_type'(4)) begin
         a = dist_type'(1);
      end else if (n <= dist_type'(8)) begin
         a = dist_type'(2);
      end else begin
         a = dist_type'(3);
      end
      return a;
   endfunction

endpackage

/* design/fzm_csr.sv */
// Configuration registers of the fuzzy substring matcher: query text and length.
// Depends on fzm_pkg.
module fzm_csr import fzm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 write_en,
   input  logic [CsrIdxW-1:0]   write_index,
   input  logic [CsrDataW-1:0]  write_data,
   output logic [QueryBits-1:0] query,
   output dist_type             query_len
);

   logic [CsrDataW-1:0] low_ff,  low_in;
   logic [CsrDataW-1:0] high_ff, high_in;
   logic [LenWidth-1:0] len_ff,  len_in;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      len_in  = len_ff;
      if (write_en) begin
         unique case (write_index)
            CSR_QUERY_LOW:  low_in  = write_data;
            CSR_QUERY_HIGH: high_in = write_data;
            CSR_QUERY_LEN:  len_in  = write_data[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
         len_ff  <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         len_ff  <= len_in;
      end
   end

   assign query = {high_ff, low_ff};

   // Lengths beyond the query capacity saturate.
   assign query_len = (len_ff > LenWidth'(MaxQuery)) ? dist_type'(MaxQuery)
                                                     : dist_type'(len_ff);

endmodule

/* design/fzm_ctrl.sv */
// Controller of the fuzzy substring matcher: handshakes and the row sweep sequencer.
// Depends on fzm_pkg; drives the datapath through a command struct.
module fzm_ctrl import fzm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_kind,
   input  logic               rsp_tready,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COLUMN  = 2'd1;
   localparam logic [1:0] ST_RESTART = 2'd2;

   logic [1:0] state_ff, state_in;
   dist_type   row_ff,   row_in;
   logic       req_fire;
   logic       csr_restart;

   // The input side stays closed while a register write is offered, so a write and
   // a beat are never taken in the same cycle.
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid &&
                       (!status.out_full || rsp_tready);
   assign csr_ready  = (state_ff != ST_COLUMN);
   assign req_fire   = req_tvalid && req_tready;
   // Only a write to a known register clears the name in progress.
   assign csr_restart = csr_valid && csr_ready &&
                        (csr_index inside {CSR_QUERY_LOW, CSR_QUERY_HIGH, CSR_QUERY_LEN});

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      cmd      = '0;
      cmd.row  = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_restart) begin
               state_in = ST_RESTART;
            end else if (req_fire) begin
               if (req_kind == KIND_END) begin
                  cmd.close_name = 1'b1;
               end else begin
                  cmd.load_char = 1'b1;
                  row_in        = '0;
                  state_in      = ST_COLUMN;
               end
            end
         end
         ST_COLUMN: begin
            cmd.step      = 1'b1;
            cmd.last_step = (row_ff == dist_type'(MaxQuery));
            row_in        = row_ff + dist_type'(1);
            if (cmd.last_step) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESTART: begin
            cmd.restart = 1'b1;
            if (csr_restart) begin
               state_in = ST_RESTART;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

endmodule

/* design/fzm_dpath.sv */
// Datapath of the fuzzy substring matcher: column shift lines, one distance cell,
// running minimum and the result register. Depends on fzm_pkg.
module fzm_dpath import fzm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [7:0]           symbol,
   input  logic [QueryBits-1:0] query,
   input  dist_type             query_len,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic                 rsp_matched,
   output dist_type             rsp_distance
);

   // Both columns rotate one entry per step, so the cell always reads the heads.
   dist_type   last_ff   [ColDepth];
   dist_type   before_ff [ColDepth];
   dist_type   lag_last_ff;
   dist_type   lag_before1_ff;
   dist_type   lag_before2_ff;
   dist_type   fresh_prev_ff;
   logic [7:0] qlag_ff;
   logic [7:0] char_ff;
   logic [7:0] prev_sym_ff;
   logic       have_prev_ff;
   dist_type   best_ff;
   logic       out_valid_ff;
   logic       out_matched_ff;
   dist_type   out_distance_ff;

   dist_type          row_minus1;
   logic [7:0]        q_cur;
   logic              cost;
   logic [RowWidth:0] cand_ins, cand_del, cand_sub, cand_tr, best_cand;
   logic              trans_ok;
   dist_type          fresh_in;
   dist_type          name_dist;
   dist_type          allow;
   logic              name_match;
   logic              restart_name;

   assign row_minus1 = cmd.row - dist_type'(1);
   assign q_cur      = query_char(query, row_minus1[CharIdxW-1:0]);
   assign cost       = (q_cur != char_ff);

   always_comb begin
      cand_ins = {1'b0, fresh_prev_ff} + (RowWidth+1)'(1);
      cand_del = {1'b0, last_ff[0]} + (RowWidth+1)'(1);
      cand_sub = {1'b0, lag_last_ff} + (RowWidth+1)'(cost);
      cand_tr  = {1'b0, lag_before2_ff} + (RowWidth+1)'(1);
      trans_ok = (cmd.row > dist_type'(1)) && have_prev_ff &&
                 (q_cur == prev_sym_ff) && (qlag_ff == char_ff);
      best_cand = (cand_ins < cand_del) ? cand_ins : cand_del;
      if (cand_sub < best_cand) begin
         best_cand = cand_sub;
      end
      if (trans_ok && cand_tr < best_cand) begin
         best_cand = cand_tr;
      end
      if (cmd.row == '0) begin
         fresh_in = '0;
      end else if (cmd.row > query_len) begin
         fresh_in = cmd.row;
      end else begin
         fresh_in = best_cand[RowWidth-1:0];
      end
   end

   assign name_dist  = (best_ff < query_len) ? best_ff : query_len;
   assign allow      = allowance(query_len);
   assign name_match = (query_len == '0) || (name_dist == '0) ||
                       (allow != '0 && name_dist <= allow);
   assign restart_name = cmd.restart || cmd.close_name;

   always_ff @(posedge clock) begin
      if (reset || restart_name) begin
         for (int j = 0; j < ColDepth; j++) begin
            last_ff[j]   <= dist_type'(j);
            before_ff[j] <= '0;
         end
         prev_sym_ff  <= '0;
         have_prev_ff <= 1'b0;
         best_ff      <= reset ? '0 : query_len;
      end else if (cmd.step) begin
         for (int j = 0; j < ColDepth - 1; j++) begin
            last_ff[j]   <= last_ff[j+1];
            before_ff[j] <= before_ff[j+1];
         end
         last_ff[ColDepth-1]   <= fresh_in;
         before_ff[ColDepth-1] <= last_ff[0];
         if (cmd.row == query_len && fresh_in < best_ff) begin
            best_ff <= fresh_in;
         end
         if (cmd.last_step) begin
            prev_sym_ff  <= char_ff;
            have_prev_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= fold(symbol);
      end
      if (cmd.step) begin
         lag_last_ff    <= last_ff[0];
         lag_before1_ff <= before_ff[0];
         lag_before2_ff <= lag_before1_ff;
         fresh_prev_ff  <= fresh_in;
         qlag_ff        <= q_cur;
      end
      if (cmd.close_name) begin
         out_matched_ff  <= name_match;
         out_distance_ff <= name_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.close_name) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.out_full = out_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_matched     = out_matched_ff;
   assign rsp_distance    = out_distance_ff;

endmodule

/* design/fuzzy_substring_matcher.sv */
// Top level of the fuzzy substring matcher: ports, register block, controller, datapath.
// Depends on fzm_pkg, fzm_csr, fzm_ctrl, fzm_dpath and fuzzy_substring_matcher_defines.svh.
`include "fuzzy_substring_matcher_defines.svh"

// The block finds how closely a query of up to 16 characters occurs anywhere inside a
// streamed candidate name, counting inserts, deletes, substitutions and swaps of two
// neighboring characters, with A-Z folded to lower case on both sides. Write the query
// text and its length over the csr port, then send the name one character beat at a
// time (tuser low) and close it with an end beat (tuser high). The end beat returns one
// result beat carrying the least distance and whether it lies within the allowance
// (none below three query characters, one up to four, two up to eight, else three; an
// empty query always matches), and the name state starts over for the next candidate.
// Each accepted character starts a row sweep, in which a single distance cell walks the
// 17 rows of the column while both stored columns rotate past it one entry per cycle;
// no input beat is taken until the sweep ends. An end beat's result sits in the output
// register in the cycle after it is taken; while that result waits no further input beat
// is taken, though the next one can be taken in the cycle in which the result leaves. A
// write to a query register passes through a restart state, in which the name in
// progress is cleared; a write to an unknown index changes nothing. The input channel
// stays closed while a configuration write is offered.
module fuzzy_substring_matcher import fzm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Input channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] symbol
   input  logic                req_tuser,   // [0] kind
   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [0] matched, [5:1] distance, [7:6] zero
   // Configuration write channel.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   logic [QueryBits-1:0] query;
   dist_type             query_len;
   dp_cmd_type           cmd;
   dp_status_type        status;
   logic                 rsp_matched;
   dist_type             rsp_distance;

   fzm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid && csr_ready),
      .write_index (csr_index),
      .write_data  (csr_data),
      .query       (query),
      .query_len   (query_len)
   );

   fzm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .status     (status),
      .cmd        (cmd)
   );

   fzm_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .symbol       (req_tdata),
      .query        (query),
      .query_len    (query_len),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_matched  (rsp_matched),
      .rsp_distance (rsp_distance)
   );

   assign rsp_tdata = {2'b00, rsp_distance, rsp_matched};

   // A result appears only right after an end beat was taken.
   `FZM_ASSERT_IMPLY(a_rsp_from_end, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tuser), "result beat without an end beat")
   // An accepted end beat always leaves a result waiting in the output register.
   `FZM_ASSERT_NEXT(a_end_gives_rsp, req_tvalid && req_tready && req_tuser, rsp_tvalid, "end beat lost its result")
   // A character starts the row sweep, so the input side must close for the next cycle.
   `FZM_ASSERT_NEXT(a_char_busy, req_tvalid && req_tready && !req_tuser, !req_tready, "input open during row sweep")
   // The distance never exceeds the query capacity and the pad bits stay clear.
   `FZM_ASSERT_IMPLY(a_rsp_range, rsp_tvalid, rsp_tdata[5:1] <= 5'd16 && rsp_tdata[7:6] == 2'b00, "result distance out of range")

endmodule
